// ----- src/ept_page_walker_assert.svh -----
// ----------------------------------------------------------------------------
// ept_page_walker assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef EPT_PAGE_WALKER_ASSERT_SVH
`define EPT_PAGE_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define EPW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`define EPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define EPW_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define EPW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/epw_pkg.sv -----
// ----------------------------------------------------------------------------
// epw_pkg
// Types and constants of the EPT page walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epw_pkg;

   localparam int HOST_PA_BITS = 52;
   localparam int ADDR_W       = 52;
   localparam int GADDR_W      = 48;
   localparam int ENTRY_W      = 64;
   localparam int ROOT_W       = 40;

   localparam logic [ADDR_W-1:0] ADDR_MASK  =
      ADDR_W'((65'd1 << HOST_PA_BITS) - 65'd1);
   localparam logic [ADDR_W-1:0] FRAME_MASK =
      ADDR_MASK & ~{{(ADDR_W-12){1'b0}}, 12'hfff};
   localparam logic [ADDR_W-1:0] BIG_MASK   =
      ADDR_MASK & ~{{(ADDR_W-21){1'b0}}, 21'h1fffff};

   localparam int LARGE_BIT = 7;

   typedef enum logic {
      FUNC_TRANSLATE = 1'b0,
      FUNC_ENTRY     = 1'b1
   } func_type;

   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      LVL_IDLE = 3'd0,
      LVL_1    = 3'd1,
      LVL_2    = 3'd2,
      LVL_3    = 3'd3,
      LVL_4    = 3'd4
   } level_type;

   typedef struct packed {
      func_type             func;
      logic [GADDR_W-1:0]   guest_addr;
      logic [ENTRY_W-1:0]   entry_data;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [ADDR_W-1:0]    entry_addr;
      logic [ADDR_W-1:0]    host_addr;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/ept_page_walker.sv -----
// ----------------------------------------------------------------------------
// ept_page_walker
// Four-level extended page table walk, guest-physical to host-physical.
// ----------------------------------------------------------------------------
// A translate beat starts a walk and yields a read request for the level-4
// entry; each returned entry beat yields the next request or the finished
// host address (2 MB page at the directory level when bit 7 is set). Every
// accepted beat is handled by the walk state register and the result register,
// so one beat per cycle is taken while the result side keeps up; a held
// result blocks input only if it is not taken that cycle.
// Translate beats during a walk and entry beats while idle are dropped.
// The root frame is sampled when a walk starts.
`timescale 1ns / 1ps
`default_nettype none

`include "ept_page_walker_assert.svh"

module ept_page_walker
   import epw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [ROOT_W-1:0] csr_data,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_type           rsp_data
);

   level_type           state_ff, state_in;
   logic [GADDR_W-1:0]  saved_ga_ff, saved_ga_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                emit;
   logic [ADDR_W-1:0]   ent_frame;
   logic [ADDR_W-1:0]   ent_big;
   logic [ADDR_W-1:0]   root_base;
   logic [8:0]          next_idx;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign root_in   = (csr_valid && csr_ready) ? csr_data : root_ff;
   assign root_base = {root_ff, 12'h000} & FRAME_MASK;
   assign ent_frame = req_data.entry_data[ADDR_W-1:0] & FRAME_MASK;
   assign ent_big   = req_data.entry_data[ADDR_W-1:0] & BIG_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LVL_IDLE;
         saved_ga_ff  <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         saved_ga_ff  <= saved_ga_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      saved_ga_in = saved_ga_ff;
      rsp_in      = rsp_ff;
      emit        = 1'b0;
      next_idx    = '0;
      if (accept) begin
         case (state_ff)
            LVL_IDLE: begin
               if (req_data.func == FUNC_TRANSLATE) begin
                  saved_ga_in       = req_data.guest_addr;
                  state_in          = LVL_4;
                  emit              = 1'b1;
                  rsp_in.kind       = KIND_READ;
                  rsp_in.entry_addr = root_base |
                     {{(ADDR_W-12){1'b0}}, req_data.guest_addr[47:39], 3'b000};
                  rsp_in.host_addr  = '0;
               end
            end
            LVL_4, LVL_3, LVL_2, LVL_1: begin
               if (req_data.func == FUNC_ENTRY) begin
                  emit = 1'b1;
                  if (state_ff == LVL_2 && req_data.entry_data[LARGE_BIT]) begin
                     state_in          = LVL_IDLE;
                     rsp_in.kind       = KIND_DONE;
                     rsp_in.entry_addr = '0;
                     rsp_in.host_addr  = ent_big |
                        {{(ADDR_W-21){1'b0}}, saved_ga_ff[20:0]};
                  end else if (state_ff == LVL_1) begin
                     state_in          = LVL_IDLE;
                     rsp_in.kind       = KIND_DONE;
                     rsp_in.entry_addr = '0;
                     rsp_in.host_addr  = ent_frame |
                        {{(ADDR_W-12){1'b0}}, saved_ga_ff[11:0]};
                  end else begin
                     case (state_ff)
                        LVL_4: begin
                           state_in = LVL_3;
                           next_idx = saved_ga_ff[38:30];
                        end
                        LVL_3: begin
                           state_in = LVL_2;
                           next_idx = saved_ga_ff[29:21];
                        end
                        default: begin
                           state_in = LVL_1;
                           next_idx = saved_ga_ff[20:12];
                        end
                     endcase
                     rsp_in.kind       = KIND_READ;
                     rsp_in.entry_addr = ent_frame |
                        {{(ADDR_W-12){1'b0}}, next_idx, 3'b000};
                     rsp_in.host_addr  = '0;
                  end
               end
            end
            default: begin
               state_in = LVL_IDLE;
            end
         endcase
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   `EPW_ASSERT_NEXT(a_start_req, clock, reset, accept && state_ff == LVL_IDLE && req_data.func == FUNC_TRANSLATE, rsp_valid_ff && rsp_ff.kind == KIND_READ && state_ff == LVL_4)
   `EPW_ASSERT_IMPLIES(a_done_idle, clock, reset, emit && rsp_in.kind == KIND_DONE, state_in == LVL_IDLE)
   `EPW_ASSERT_IMPLIES(a_req_align, clock, reset, rsp_valid_ff && rsp_ff.kind == KIND_READ, rsp_ff.entry_addr[2:0] == 3'b000 && rsp_ff.host_addr == '0)
   `EPW_ASSERT_NEXT(a_busy_hold, clock, reset, accept && state_ff != LVL_IDLE && req_data.func == FUNC_TRANSLATE, saved_ga_ff == $past(saved_ga_ff))

endmodule

`default_nettype wire
